@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros shared by the RTL.
// Needs a clock named clock and a reset named reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check expr at every rising edge outside of reset.
`define EIA_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// Check that cause at one edge implies effect at the next edge.
`define EIA_ASSERT_NEXT(label, cause, effect) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/eia_pkg.sv @@
// Package for the entity id allocator: sizes, codes and payload structs.
// No dependencies.
package eia_pkg;

   localparam int MAX_IDS = 1024;
   localparam int ID_W    = 10;
   localparam int CNT_W   = 11;
   localparam int ATTR_W  = 32;

   typedef enum logic [1:0] {
      ACT_CREATE = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_ASSIGN = 2'd2,
      ACT_GET    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOT_LIVE = 2'd2
   } status_type;

   typedef struct packed {
      action_type        action;
      logic [ID_W-1:0]   target_id;
      logic [ATTR_W-1:0] attr_value;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   result_id;
      logic [ATTR_W-1:0] attr_out;
      logic [CNT_W-1:0]  live_count;
   } rsp_type;

   // controller -> datapath commands
   typedef struct packed {
      logic capture;   // latch request, launch memory reads
      logic execute;   // update state, load result register
   } cmd_type;

   typedef struct packed {
      logic              live;
      logic [ATTR_W-1:0] attr;
   } entry_type;

endpackage

@@ hw/rtl/entity_id_allocator_unit.sv @@
// Entity id allocator: LIFO free-id stack plus per-id live flag and attribute word.
// A request transaction is captured with a registered read of the stack and id table,
// then executed into the result register once that register is free. One transaction at
// a time: a new request waits until the last has executed. Result register frees input.
// Reset: synchronous, active high; the block is usable the cycle after reset, no clearing
// pass (reset-state ids and live flags are derived from the lowest stack depth reached).
module entity_id_allocator_unit
   import eia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "assert_macros.svh"

   cmd_type cmd;

   // sequencer: accept, then execute once the result register is free
   eia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // stack, id table, counters and result register
   eia_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // a request transaction blocks the input for the next cycle
   `EIA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   // every execute presents a result in the following cycle
   `EIA_ASSERT_NEXT(a_exec_gives_rsp, cmd.execute, rsp_valid)
   // capture and execute belong to different states
   `EIA_ASSERT(a_cmd_exclusive, !(cmd.capture && cmd.execute))
   // live count can never exceed the id space
   `EIA_ASSERT(a_live_bound, !rsp_valid || (rsp_data.live_count <= CNT_W'(MAX_IDS)))

endmodule

@@ hw/rtl/eia_ctrl.sv @@
// Controller for the entity id allocator: two-state sequencer plus result valid.
// Depends on eia_pkg.
module eia_ctrl
   import eia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/eia_datapath.sv @@
// Datapath for the entity id allocator: free stack, id table, counters, result.
// Depends on eia_pkg; driven by eia_ctrl commands.
module eia_datapath
   import eia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output rsp_type rsp_data
);

   logic [ID_W-1:0] stack_mem [MAX_IDS];
   entry_type       table_mem [MAX_IDS];

   req_type          req_ff;
   logic [ID_W-1:0]  stk_rd_ff;
   logic             stk_fresh_ff;
   entry_type        tbl_rd_ff;
   logic             handed_ff;
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0] min_depth_ff, min_depth_in;
   logic [CNT_W-1:0] live_total_ff, live_total_in;
   rsp_type          rsp_ff, rsp_in;

   logic [ID_W-1:0]  top_slot;
   logic [ID_W-1:0]  pop_id;
   logic [CNT_W-1:0] depth_dec;
   logic [CNT_W-1:0] handed_limit;
   logic             target_live;
   logic             stk_we;
   logic             tbl_we;
   logic [ID_W-1:0]  tbl_waddr;
   entry_type        tbl_wdata;

   assign top_slot     = depth_ff[ID_W-1:0] - ID_W'(1);
   assign depth_dec    = depth_ff - CNT_W'(1);
   // ids below this bound have been popped at least once, so their table entry is real
   assign handed_limit = CNT_W'(MAX_IDS) - min_depth_ff;
   // slots below min_depth were never pushed: they still hold the reset ordering
   assign pop_id       = stk_fresh_ff ? (ID_W'(MAX_IDS - 1) - top_slot) : stk_rd_ff;
   assign target_live  = handed_ff && tbl_rd_ff.live;

   always_comb begin
      depth_in        = depth_ff;
      min_depth_in    = min_depth_ff;
      live_total_in   = live_total_ff;
      stk_we          = 1'b0;
      tbl_we          = 1'b0;
      tbl_waddr       = req_ff.target_id;
      tbl_wdata       = '0;
      rsp_in.status     = ST_OK;
      rsp_in.result_id  = req_ff.target_id;
      rsp_in.attr_out   = '0;
      rsp_in.live_count = live_total_ff;
      if (req_ff.action == ACT_CREATE) begin
         if (depth_ff == '0) begin
            rsp_in.status    = ST_EMPTY;
            rsp_in.result_id = '0;
         end else begin
            depth_in       = depth_dec;
            min_depth_in   = (depth_dec < min_depth_ff) ? depth_dec : min_depth_ff;
            live_total_in  = live_total_ff + CNT_W'(1);
            tbl_we         = 1'b1;
            tbl_waddr      = pop_id;
            tbl_wdata.live = 1'b1;
            rsp_in.result_id  = pop_id;
            rsp_in.live_count = live_total_ff + CNT_W'(1);
         end
      end else if (!target_live) begin
         rsp_in.status = ST_NOT_LIVE;
      end else begin
         unique case (req_ff.action)
            ACT_DELETE: begin
               tbl_we = 1'b1;
               if (depth_ff < CNT_W'(MAX_IDS)) begin
                  stk_we   = 1'b1;
                  depth_in = depth_ff + CNT_W'(1);
               end
               if (live_total_ff != '0) begin
                  live_total_in     = live_total_ff - CNT_W'(1);
                  rsp_in.live_count = live_total_ff - CNT_W'(1);
               end
            end
            ACT_ASSIGN: begin
               tbl_we         = 1'b1;
               tbl_wdata.live = 1'b1;
               tbl_wdata.attr = req_ff.attr_value;
            end
            ACT_GET: begin
               rsp_in.attr_out = tbl_rd_ff.attr;
            end
            default: begin
               rsp_in.attr_out = '0;
            end
         endcase
      end
   end

   // free stack memory
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         stk_rd_ff <= stack_mem[top_slot];
      end
      if (cmd.execute && stk_we) begin
         stack_mem[depth_ff[ID_W-1:0]] <= req_ff.target_id;
      end
   end

   // per-id live flag and attribute table
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tbl_rd_ff <= table_mem[req_data.target_id];
      end
      if (cmd.execute && tbl_we) begin
         table_mem[tbl_waddr] <= tbl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff       <= req_data;
         stk_fresh_ff <= {1'b0, top_slot} < min_depth_ff;
         handed_ff    <= {1'b0, req_data.target_id} < handed_limit;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= CNT_W'(MAX_IDS);
         min_depth_ff  <= CNT_W'(MAX_IDS);
         live_total_ff <= '0;
      end else if (cmd.execute) begin
         depth_ff      <= depth_in;
         min_depth_ff  <= min_depth_in;
         live_total_ff <= live_total_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ dv/entity_id_allocator_unit_tb.sv @@
// Testbench for entity_id_allocator_unit: directed and random create/delete/assign/get traffic
// with random idling on both channels, checked against an in-bench model of the id free list.
// Depends on eia_pkg (payload structs, action and status codes) and the RTL top level.
`timescale 1ns / 100ps

module entity_id_allocator_unit_tb;
   import eia_pkg::*;

   // run limits: the worst item costs a maximal idle gap, its pass through the block and a
   // maximal result stall; CYCLE_LIMIT leaves room for about 750 such items with margin
   localparam int CYCLE_LIMIT  = 150000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 50;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   entity_id_allocator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Free-list model. Slot free_depth-1 is the top of the LIFO; reset leaves id 0 there.
   // ---------------------------------------------------------------------------------
   logic [ID_W-1:0]   free_ids [MAX_IDS];
   int                free_depth;
   logic [ATTR_W-1:0] attr_mem [MAX_IDS];
   bit                live_flag [MAX_IDS];
   int                live_total;

   // ids currently live, kept for stimulus so it can aim at real entries
   logic [ID_W-1:0]   live_ids [$];

   // responses predicted at request acceptance, oldest first
   rsp_type           pending_rsp_q [$];

   // bookkeeping for the end-of-run summary and failure tracking
   int mismatch_count = 0;
   int req_count      = 0;
   int rsp_count      = 0;
   int empty_hits     = 0;
   int dead_id_hits   = 0;
   int peak_live      = 0;
   int cycle_count    = 0;

   // percentage of transactions preceded by an idle gap, per side
   int idle_pct  = 40;
   int stall_pct = 40;

   task automatic clear_alloc_model();
      for (int k = 0; k < MAX_IDS; k++) begin
         free_ids[k]  = ID_W'(MAX_IDS - k - 1);
         live_flag[k] = 1'b0;
         attr_mem[k]  = '0;
      end
      free_depth = MAX_IDS;
      live_total = 0;
      live_ids.delete();
   endtask

   // Apply one request to the model and return the response the block must give.
   function automatic rsp_type predict_alloc_rsp(req_type rq);
      rsp_type         r;
      logic [ID_W-1:0] id;
      int              hit [$];
      r.status    = ST_OK;
      r.result_id = rq.target_id;
      r.attr_out  = '0;
      if (rq.action == ACT_CREATE) begin
         if (free_depth == 0) begin
            // stack exhausted: refuse and leave everything alone
            r.status    = ST_EMPTY;
            r.result_id = '0;
            empty_hits++;
         end else begin
            free_depth--;
            id            = free_ids[free_depth];
            live_flag[id] = 1'b1;
            attr_mem[id]  = '0;
            live_total++;
            r.result_id   = id;
            live_ids.push_back(id);
         end
      end else if (!live_flag[rq.target_id]) begin
         r.status = ST_NOT_LIVE;
         dead_id_hits++;
      end else begin
         case (rq.action)
            ACT_DELETE: begin
               live_flag[rq.target_id] = 1'b0;
               free_ids[free_depth]    = rq.target_id;
               free_depth++;
               live_total--;
               hit = live_ids.find_first_index(x) with (x == rq.target_id);
               if (hit.size() != 0)
                  live_ids.delete(hit[0]);
            end
            ACT_ASSIGN: attr_mem[rq.target_id] = rq.attr_value;
            default:    r.attr_out = attr_mem[rq.target_id];
         endcase
      end
      r.live_count = CNT_W'(live_total);
      if (live_total > peak_live)
         peak_live = live_total;
      return r;
   endfunction

   function automatic int draw_idle(int pct);
      if ($urandom_range(0, 99) < pct)
         return int'($urandom_range(0, 17));
      return 0;
   endfunction

   // Send one request transaction. Entered just after a rising edge; leaves valid high on
   // return so that a back-to-back request never drops it within the same step.
   task automatic issue_alloc_req(action_type act, logic [ID_W-1:0] id,
                                  logic [ATTR_W-1:0] val);
      req_type rq;
      int      gap;
      rq.action     = act;
      rq.target_id  = id;
      rq.attr_value = val;
      gap = draw_idle(idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      // accepted at this edge: model the effect right away so stimulus sees fresh state
      pending_rsp_q.push_back(predict_alloc_rsp(rq));
      req_count++;
   endtask

   function automatic logic [ID_W-1:0] any_id();
      return ID_W'($urandom_range(0, MAX_IDS - 1));
   endfunction

   // mostly a live id, now and then any id (usually a dead one)
   function automatic logic [ID_W-1:0] pick_target();
      if (live_ids.size() != 0 && $urandom_range(0, 9) != 0)
         return live_ids[$urandom_range(0, live_ids.size() - 1)];
      return any_id();
   endfunction

   // ---------------------------------------------------------------------------------
   // Result side: random stall per transaction, then hold ready until one is taken.
   // ---------------------------------------------------------------------------------
   initial begin : rsp_sink
      int stall;
      forever begin
         stall = draw_idle(stall_pct);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want_v, got_v);
      end
   endtask

   // Every accepted result transaction is matched against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (pending_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none actual %0h", $time, rsp_data);
         end else begin
            want = pending_rsp_q.pop_front();
            check_field("status",     32'(want.status),     32'(rsp_data.status));
            check_field("result_id",  32'(want.result_id),  32'(rsp_data.result_id));
            check_field("attr_out",   want.attr_out,        rsp_data.attr_out);
            check_field("live_count", 32'(want.live_count), 32'(rsp_data.live_count));
         end
      end
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_rsp_q.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Dead-id requests from reset, first creates, attribute extremes, double delete and
   // LIFO reuse with attributes cleared on re-create.
   task automatic test_directed_basics();
      idle_pct  = 40;
      stall_pct = 40;
      issue_alloc_req(ACT_GET,    '0,          '0);            // nothing live yet
      issue_alloc_req(ACT_DELETE, ID_W'(5),    '0);
      issue_alloc_req(ACT_ASSIGN, '1,          '1);
      issue_alloc_req(ACT_CREATE, '1,          '1);            // id 0, target ignored
      issue_alloc_req(ACT_CREATE, '0,          '0);            // id 1
      issue_alloc_req(ACT_CREATE, ID_W'(512),  32'h1234_5678); // id 2
      issue_alloc_req(ACT_GET,    '0,          '1);            // freshly cleared
      issue_alloc_req(ACT_ASSIGN, '0,          '1);
      issue_alloc_req(ACT_GET,    '0,          '0);
      issue_alloc_req(ACT_ASSIGN, ID_W'(1),    32'hAAAA_AAAA);
      issue_alloc_req(ACT_GET,    ID_W'(1),    '0);
      issue_alloc_req(ACT_ASSIGN, ID_W'(1),    32'h5555_5555);
      issue_alloc_req(ACT_GET,    ID_W'(1),    '0);
      issue_alloc_req(ACT_DELETE, ID_W'(1),    '0);
      issue_alloc_req(ACT_DELETE, ID_W'(1),    '0);            // already returned
      issue_alloc_req(ACT_GET,    ID_W'(1),    '0);
      issue_alloc_req(ACT_ASSIGN, ID_W'(1),    '1);
      issue_alloc_req(ACT_CREATE, '1,          '1);            // reuses 1, attrs cleared
      issue_alloc_req(ACT_GET,    ID_W'(1),    '0);
      issue_alloc_req(ACT_DELETE, '0,          '0);
      issue_alloc_req(ACT_DELETE, ID_W'(2),    '0);
      issue_alloc_req(ACT_CREATE, '0,          '0);            // pops 2 (last in)
      issue_alloc_req(ACT_CREATE, '0,          '0);            // then 0
      issue_alloc_req(ACT_CREATE, '0,          '0);            // then 3 from the reset order
   endtask

   // Random mix; create_pct and delete_pct steer live_count up or down.
   task automatic test_random_traffic(int n_items, int create_pct, int delete_pct,
                                      int idle_mix);
      int roll;
      idle_pct  = idle_mix;
      stall_pct = idle_mix;
      repeat (n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < create_pct)
            issue_alloc_req(ACT_CREATE, any_id(), $urandom);
         else if (roll < create_pct + delete_pct)
            issue_alloc_req(ACT_DELETE, pick_target(), $urandom);
         else if ($urandom_range(0, 1) == 0)
            issue_alloc_req(ACT_ASSIGN, pick_target(), $urandom);
         else
            issue_alloc_req(ACT_GET, pick_target(), $urandom);
      end
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0)
         @(posedge clock);
      // let any stray extra result show up before closing
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests, %0d results; %0d creates on an empty stack, %0d dead-id requests",
               req_count, rsp_count, empty_hits, dead_id_hits);
      $display("live count peaked at %0d, ending at %0d", peak_live, live_total);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   endtask

   initial begin
      clear_alloc_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_random_traffic(250, 45, 15, 40);   // grow
      test_random_traffic(250, 20, 40, 40);   // shrink
      test_random_traffic(150, 30, 30, 0);    // back to back, no idling
      test_random_traffic(80, 30, 25, 60);
      finish_run();
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/eia_pkg.sv
hw/rtl/eia_ctrl.sv
hw/rtl/eia_datapath.sv
hw/rtl/entity_id_allocator_unit.sv
dv/entity_id_allocator_unit_tb.sv
